### rtl/gsq_pkg.sv
// Shared types, constants and the duty table for the two-channel square-wave sound unit.
// Used by every module of the block but gsq_ram; depends on nothing.

package gsq_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Register fields within one channel's group of five byte registers.
    localparam logic [2:0] FIELD_SWEEP     = 3'd0;
    localparam logic [2:0] FIELD_DUTY_LEN  = 3'd1;
    localparam logic [2:0] FIELD_VOL_ENV   = 3'd2;
    localparam logic [2:0] FIELD_PERIOD_LO = 3'd3;
    localparam logic [2:0] FIELD_PERIOD_HI = 3'd4;

    // Offsets of the channel register groups.
    localparam logic [5:0] CH_ONE_LAST_OFFSET  = 6'd4;
    localparam logic [5:0] CH_TWO_FIRST_OFFSET = 6'd6;
    localparam logic [5:0] CH_TWO_LAST_OFFSET  = 6'd9;
    localparam logic [5:0] CH_TWO_FIELD_BASE   = 6'd5;

    // Step intervals in ticks.
    localparam int SWEEP_STEP_TICKS    = 32768;
    localparam int LENGTH_STEP_TICKS   = 16384;
    localparam int ENVELOPE_STEP_TICKS = 65536;

    // Register shadow.
    localparam int SHADOW_DEPTH = 48;
    localparam int SHADOW_AW    = $clog2(SHADOW_DEPTH);

    // Widths derived from the intervals.
    localparam int PERIOD_W       = 11;
    localparam int PERIOD_TIMER_W = PERIOD_W + 3;
    localparam int SWEEP_TIMER_W  = $clog2(SWEEP_STEP_TICKS + 1);
    localparam int LEN_TIMER_W    = $clog2(LENGTH_STEP_TICKS + 1);
    localparam int ENV_TIMER_W    = $clog2(ENVELOPE_STEP_TICKS + 1);

    // Length counter loaded on a trigger when it is empty.
    localparam logic [6:0] LENGTH_FULL = 7'd64;
    localparam logic [3:0] VOLUME_MAX  = 4'd15;

    // Duty waveforms, one bit per step, step zero in bit zero.
    localparam logic [7:0] DUTY_TABLE [4] = '{
        8'b1000_0000,
        8'b1000_0001,
        8'b1110_0001,
        8'b0111_1110
    };

    // One input transfer.
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] reg_offset;
        logic [7:0] write_data;
    } item_t;

    // One result transfer.
    typedef struct packed {
        logic [5:0] sample;
        logic [7:0] read_data;
        logic       chan_one_on;
        logic       chan_two_on;
    } result_t;

    // Register write aimed at one channel.
    typedef struct packed {
        logic       en;
        logic [2:0] field;
        logic [7:0] data;
    } wr_req_t;

    // Sweep unit control toward channel one.
    typedef struct packed {
        logic                kill;
        logic                load;
        logic [PERIOD_W-1:0] period;
    } sweep_ctl_t;

    // Channel state after the step, as the mixer needs it.
    typedef struct packed {
        logic       on;
        logic [4:0] amp;
    } chan_status_t;

endpackage

### rtl/gsq_ram.sv
// Generic single-port RAM with a registered read, used for the register shadow.
// Depends on nothing.

module gsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read share one address.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/gsq_sweep.sv
// Frequency sweep unit of channel one: sweep registers, step timer and period updates.
// Depends on gsq_pkg.

module gsq_sweep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  gsq_pkg::wr_req_t             wr,
    input  logic [gsq_pkg::PERIOD_W-1:0] period,
    output gsq_pkg::sweep_ctl_t          ctl
);

    localparam int PW = gsq_pkg::PERIOD_W;
    localparam int TW = gsq_pkg::SWEEP_TIMER_W;

    typedef struct packed {
        logic          ovf;
        logic          upd;
        logic [PW-1:0] val;
    } calc_t;

    // One sweep calculation with its overflow re-check on the new period.
    function automatic calc_t sweep_calc(input logic [PW-1:0] pc, input logic [PW-1:0] sh,
                                         input logic [2:0] shift, input logic down);
        logic [PW:0]   n1;
        logic [PW:0]   n2;
        logic [PW-1:0] d1;
        logic [PW-1:0] d2;
        calc_t         r;
        d1 = sh >> shift;
        n1 = down ? ({1'b0, pc} - {1'b0, d1}) : ({1'b0, pc} + {1'b0, d1});
        d2 = n1[PW-1:0] >> shift;
        n2 = down ? ({1'b0, n1[PW-1:0]} - {1'b0, d2}) : ({1'b0, n1[PW-1:0]} + {1'b0, d2});
        r.upd = !n1[PW] && (shift != 3'd0);
        r.val = n1[PW-1:0];
        r.ovf = n1[PW] || (r.upd && n2[PW]);
        return r;
    endfunction

    logic [2:0]    per_reg, per_next;
    logic          down_reg, down_next;
    logic [2:0]    shift_reg, shift_next;
    logic [TW-1:0] tmr_reg, tmr_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          active_reg, active_next;
    logic [PW-1:0] shadow_reg, shadow_next;

    calc_t         calc_a;
    calc_t         calc_b;
    logic          fire;
    logic          run_a;
    logic          run_b;
    logic [PW-1:0] pc1;
    logic [PW-1:0] sh1;

    // Sweep step: optional calculation, then reload or count down; or a sweep register write.
    always_comb
    begin
        per_next    = per_reg;
        down_next   = down_reg;
        shift_next  = shift_reg;
        tmr_next    = tmr_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        shadow_next = shadow_reg;
        ctl         = '0;

        fire   = (tmr_reg <= TW'(1));
        run_a  = active_reg && (per_reg != 3'd0);
        calc_a = sweep_calc(period, shadow_reg, shift_reg, down_reg);
        pc1    = (run_a && calc_a.upd) ? calc_a.val : period;
        sh1    = (run_a && calc_a.upd) ? calc_a.val : shadow_reg;
        run_b  = (cnt_reg <= 3'd1) && (shift_reg != 3'd0);
        calc_b = sweep_calc(pc1, pc1, shift_reg, down_reg);

        if (tick)
        begin
            if (fire)
            begin
                tmr_next   = TW'(gsq_pkg::SWEEP_STEP_TICKS - 1) + tmr_reg;
                ctl.load   = 1'b1;
                ctl.kill   = (run_a && calc_a.ovf) || (run_b && calc_b.ovf);
                ctl.period = pc1;
                if (cnt_reg <= 3'd1)
                begin
                    cnt_next    = per_reg;
                    active_next = (per_reg != 3'd0) || (shift_reg != 3'd0);
                    shadow_next = pc1;
                    if (run_b && calc_b.upd)
                    begin
                        ctl.period  = calc_b.val;
                        shadow_next = calc_b.val;
                    end
                end
                else
                begin
                    cnt_next    = cnt_reg - 3'd1;
                    shadow_next = sh1;
                end
            end
            else
            begin
                tmr_next = tmr_reg - TW'(1);
            end
        end
        else if (wr.en && (wr.field == gsq_pkg::FIELD_SWEEP))
        begin
            per_next   = wr.data[6:4];
            down_next  = wr.data[3];
            shift_next = wr.data[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_reg    <= '0;
            down_reg   <= 1'b0;
            shift_reg  <= '0;
            tmr_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            shadow_reg <= '0;
        end
        else
        begin
            per_reg    <= per_next;
            down_reg   <= down_next;
            shift_reg  <= shift_next;
            tmr_reg    <= tmr_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            shadow_reg <= shadow_next;
        end
    end

endmodule

### rtl/gsq_pulse.sv
// One pulse channel: duty stepping, length counter, volume envelope and register fields.
// Depends on gsq_pkg; channel one also takes period updates from gsq_sweep.

module gsq_pulse (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  gsq_pkg::wr_req_t             wr,
    input  gsq_pkg::sweep_ctl_t          sweep,
    output logic [gsq_pkg::PERIOD_W-1:0] period,
    output gsq_pkg::chan_status_t        status
);

    localparam int PW  = gsq_pkg::PERIOD_W;
    localparam int PTW = gsq_pkg::PERIOD_TIMER_W;
    localparam int LTW = gsq_pkg::LEN_TIMER_W;
    localparam int ETW = gsq_pkg::ENV_TIMER_W;

    logic [1:0]     duty_reg, duty_next;
    logic [6:0]     len_cnt_reg, len_cnt_next;
    logic [3:0]     vol_reg, vol_next;
    logic           env_down_reg, env_down_next;
    logic [PW-1:0]  period_reg, period_next;
    logic           trig_reg, trig_next;
    logic           len_en_reg, len_en_next;
    logic           on_reg, on_next;
    logic           level_reg, level_next;
    logic [2:0]     step_reg, step_next;
    logic [PTW-1:0] ptmr_reg, ptmr_next;
    logic [LTW-1:0] ltmr_reg, ltmr_next;
    logic [ETW-1:0] etmr_reg, etmr_next;

    logic [PTW-1:0] reload;

    // Duty period in ticks: four times (2048 - period code).
    assign reload = {12'd2048 - {1'b0, period_reg}, 2'b00};

    // One tick in the order trigger, duty, sweep, length, envelope; or a register write.
    always_comb
    begin
        duty_next     = duty_reg;
        len_cnt_next  = len_cnt_reg;
        vol_next      = vol_reg;
        env_down_next = env_down_reg;
        period_next   = period_reg;
        trig_next     = trig_reg;
        len_en_next   = len_en_reg;
        on_next       = on_reg;
        level_next    = level_reg;
        step_next     = step_reg;
        ptmr_next     = ptmr_reg;
        ltmr_next     = ltmr_reg;
        etmr_next     = etmr_reg;

        if (tick)
        begin
            // Trigger enables the channel and refills an empty length counter.
            if (trig_reg)
            begin
                on_next   = 1'b1;
                trig_next = 1'b0;
                if (len_cnt_reg == 7'd0)
                begin
                    len_cnt_next = gsq_pkg::LENGTH_FULL;
                end
            end

            // Duty stepping.
            if (ptmr_reg <= PTW'(1))
            begin
                ptmr_next  = reload - PTW'(1) + ptmr_reg;
                level_next = gsq_pkg::DUTY_TABLE[duty_reg][step_reg];
                step_next  = step_reg + 3'd1;
            end
            else
            begin
                ptmr_next = ptmr_reg - PTW'(1);
            end

            // Sweep results.
            if (sweep.kill)
            begin
                on_next = 1'b0;
            end
            if (sweep.load)
            begin
                period_next = sweep.period;
            end

            // Length counter runs only while it is nonzero.
            if (len_cnt_next != 7'd0)
            begin
                if (ltmr_reg <= LTW'(1))
                begin
                    ltmr_next = LTW'(gsq_pkg::LENGTH_STEP_TICKS - 1) + ltmr_reg;
                    if (len_en_reg)
                    begin
                        len_cnt_next = len_cnt_next - 7'd1;
                        if (len_cnt_next == 7'd0)
                        begin
                            on_next    = 1'b0;
                            level_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    ltmr_next = ltmr_reg - LTW'(1);
                end
            end

            // Envelope ramps by one, clamped to the volume range.
            if (etmr_reg <= ETW'(1))
            begin
                etmr_next = ETW'(gsq_pkg::ENVELOPE_STEP_TICKS - 1) + etmr_reg;
                if (env_down_reg)
                begin
                    if (vol_reg != 4'd0)
                    begin
                        vol_next = vol_reg - 4'd1;
                    end
                end
                else if (vol_reg != gsq_pkg::VOLUME_MAX)
                begin
                    vol_next = vol_reg + 4'd1;
                end
            end
            else
            begin
                etmr_next = etmr_reg - ETW'(1);
            end
        end
        else if (wr.en)
        begin
            unique case (wr.field)
                gsq_pkg::FIELD_DUTY_LEN:
                begin
                    duty_next    = wr.data[7:6];
                    len_cnt_next = {1'b0, wr.data[5:0]};
                end
                gsq_pkg::FIELD_VOL_ENV:
                begin
                    vol_next      = wr.data[7:4];
                    env_down_next = wr.data[3];
                end
                gsq_pkg::FIELD_PERIOD_LO:
                begin
                    period_next = {period_reg[PW-1:8], wr.data};
                end
                gsq_pkg::FIELD_PERIOD_HI:
                begin
                    period_next = {wr.data[2:0], period_reg[7:0]};
                    trig_next   = wr.data[7];
                    len_en_next = wr.data[6];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg     <= 2'd2;
            len_cnt_reg  <= '0;
            vol_reg      <= '0;
            env_down_reg <= 1'b0;
            period_reg   <= '0;
            trig_reg     <= 1'b0;
            len_en_reg   <= 1'b0;
            on_reg       <= 1'b0;
            level_reg    <= 1'b0;
            step_reg     <= '0;
            ptmr_reg     <= '0;
            ltmr_reg     <= '0;
            etmr_reg     <= '0;
        end
        else
        begin
            duty_reg     <= duty_next;
            len_cnt_reg  <= len_cnt_next;
            vol_reg      <= vol_next;
            env_down_reg <= env_down_next;
            period_reg   <= period_next;
            trig_reg     <= trig_next;
            len_en_reg   <= len_en_next;
            on_reg       <= on_next;
            level_reg    <= level_next;
            step_reg     <= step_next;
            ptmr_reg     <= ptmr_next;
            ltmr_reg     <= ltmr_next;
            etmr_reg     <= etmr_next;
        end
    end

    // State after the step, for the mixer and the enable flags.
    assign period     = period_reg;
    assign status.on  = on_next;
    assign status.amp = (on_next && level_next) ? ({1'b0, vol_next} + 5'd1) : 5'd0;

endmodule

### rtl/two_channel_square_wave_sound_unit.sv
// Top level of the two-channel square-wave sound unit: decode, shadow, mixer, output stages.
// Depends on gsq_pkg, gsq_ram, gsq_sweep and gsq_pulse.
//
// Usage: items come in on the item channel (item_valid, item_stall, item). Each is a
// clock tick, a byte register write or a byte register read at an offset from the sound
// base. Every item gives exactly one transfer on the result channel (result_valid,
// result_stall, result): the mixed sample for a tick, the shadow byte for a read, and
// the two channel enable flags as they stand after the item.
// Throughput is one item per clock while item_stall is low. The channel and sweep state
// is updated at the edge that accepts the item; the result then passes a stage register,
// which waits on the shadow RAM's registered read, and an output register, which drives
// result_valid.
// The shadow RAM's single port sets the stage split: one access per item.
// When the receiver stalls, the output register holds; the stage register still takes
// one more item, and item_stall rises only when both are full.
// Reset clears all channel, sweep and handshake state at once. The top level keeps a
// written flag per shadow byte, cleared by reset, so unwritten bytes read as zero with no
// clearing pass; the block accepts items as soon as reset is released.

module two_channel_square_wave_sound_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  gsq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output gsq_pkg::result_t result
);

    localparam int AW    = gsq_pkg::SHADOW_AW;
    localparam int DEPTH = gsq_pkg::SHADOW_DEPTH;

    logic                       accept;
    logic                       is_tick;
    logic                       is_write;
    logic                       is_read;
    logic                       in_range;
    logic                       wr_shadow;
    logic                       rd_shadow;
    logic [AW-1:0]              shadow_addr;
    logic [7:0]                 shadow_rd_data;
    logic [DEPTH-1:0]           shadow_vld_reg;

    gsq_pkg::wr_req_t           wr_one;
    gsq_pkg::wr_req_t           wr_two;
    gsq_pkg::sweep_ctl_t        sweep_ctl;
    gsq_pkg::chan_status_t      st_one;
    gsq_pkg::chan_status_t      st_two;
    logic [gsq_pkg::PERIOD_W-1:0] period_one;

    logic                       s1_valid_reg;
    logic [5:0]                 s1_sample_reg;
    logic                       s1_one_on_reg;
    logic                       s1_two_on_reg;
    logic                       s1_rd_ok_reg;
    logic                       s1_move;
    logic                       out_free;
    logic                       result_valid_reg;
    gsq_pkg::result_t           result_reg;

    // Handshake: the stage register advances whenever the output register is free.
    assign out_free   = !result_valid_reg || !result_stall;
    assign s1_move    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    // Item decode.
    assign is_tick     = accept && (item.kind == gsq_pkg::KIND_TICK);
    assign is_write    = accept && (item.kind == gsq_pkg::KIND_WRITE);
    assign is_read     = accept && (item.kind == gsq_pkg::KIND_READ);
    assign in_range    = ({26'd0, item.reg_offset} < DEPTH);
    assign shadow_addr = item.reg_offset[AW-1:0];
    assign wr_shadow   = is_write && in_range;
    assign rd_shadow   = is_read && in_range;

    // Channel register writes.
    always_comb
    begin
        wr_one.en    = is_write && (item.reg_offset <= gsq_pkg::CH_ONE_LAST_OFFSET);
        wr_one.field = item.reg_offset[2:0];
        wr_one.data  = item.write_data;
        wr_two.en    = is_write && (item.reg_offset >= gsq_pkg::CH_TWO_FIRST_OFFSET)
                       && (item.reg_offset <= gsq_pkg::CH_TWO_LAST_OFFSET);
        wr_two.field = 3'(item.reg_offset - gsq_pkg::CH_TWO_FIELD_BASE);
        wr_two.data  = item.write_data;
    end

    gsq_sweep u_sweep (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (is_tick),
        .wr     (wr_one),
        .period (period_one),
        .ctl    (sweep_ctl)
    );

    gsq_pulse u_chan_one (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (is_tick),
        .wr     (wr_one),
        .sweep  (sweep_ctl),
        .period (period_one),
        .status (st_one)
    );

    gsq_pulse u_chan_two (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (is_tick),
        .wr     (wr_two),
        .sweep  ('0),
        .period (),
        .status (st_two)
    );

    gsq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_shadow (
        .clk     (clk),
        .wr_en   (wr_shadow),
        .rd_en   (rd_shadow),
        .addr    (shadow_addr),
        .wr_data (item.write_data),
        .rd_data (shadow_rd_data)
    );

    // Written flags of the shadow bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_vld_reg <= '0;
        end
        else if (wr_shadow)
        begin
            shadow_vld_reg[shadow_addr] <= 1'b1;
        end
    end

    // Stage register: mixed sample and flags, waiting for the shadow read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= is_tick ? ({1'b0, st_one.amp} + {1'b0, st_two.amp}) : 6'd0;
            s1_one_on_reg <= st_one.on;
            s1_two_on_reg <= st_two.on;
            s1_rd_ok_reg  <= rd_shadow && shadow_vld_reg[shadow_addr];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            result_reg.sample      <= s1_sample_reg;
            result_reg.read_data   <= s1_rd_ok_reg ? shadow_rd_data : 8'd0;
            result_reg.chan_one_on <= s1_one_on_reg;
            result_reg.chan_two_on <= s1_two_on_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### test/two_channel_square_wave_sound_unit_tb.sv
// Testbench for the two-channel square-wave sound unit: a table of directed item transfers,
// then random register traffic and runs of ticks, each result checked against a predictor
// or, for pinned rows, a typed-in result. Depends on gsq_pkg and the RTL of the unit.

module two_channel_square_wave_sound_unit_tb;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_OPS    = 480;
    localparam int CALM_OPS      = 80;
    localparam int TICK_BUDGET   = 200;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 100;
    localparam longint RUN_LIMIT = 64'd5_000_000;

    // Item kind the block treats as a no-operation.
    localparam logic [1:0] KIND_NOP = 2'd3;

    // Predictor constants.
    localparam int          SHADOW_BYTES  = 48;
    localparam int          SWEEP_TICKS   = 32768;
    localparam int          LENGTH_TICKS  = 16384;
    localparam int          ENV_TICKS     = 65536;
    localparam int          PERIOD_SPAN   = 2048;
    localparam logic [15:0] PERIOD_MAX    = 16'd2047;
    localparam logic [6:0]  LENGTH_RELOAD = 7'd64;
    localparam logic [3:0]  VOLUME_TOP    = 4'd15;

    // Wave shapes, indexed by {duty, position}.
    localparam logic [31:0] WAVE_BITS = {8'b0111_1110, 8'b1110_0001, 8'b1000_0001, 8'b1000_0000};

    // One row of the directed stimulus; pinned rows carry their result typed in.
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] offset;
        logic [7:0] data;
        logic       pinned;
        logic [5:0] sample;
        logic [7:0] read_data;
        logic       one_on;
        logic       two_on;
    } probe_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam probe_row_t PROBES [DIRECTED_ROWS] = '{
        '{gsq_pkg::KIND_READ,  6'd0,  8'h00, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_TICK,  6'd0,  8'h00, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd63, 8'hFF, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_READ,  6'd63, 8'h00, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd48, 8'h5A, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_READ,  6'd48, 8'h00, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{KIND_NOP,            6'd63, 8'hFF, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd47, 8'hA5, 1'b1, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_READ,  6'd47, 8'h00, 1'b1, 6'd0, 8'hA5, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd0,  8'h7F, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd1,  8'hC1, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd2,  8'hF0, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd3,  8'hFF, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd4,  8'h87, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_TICK,  6'd0,  8'h00, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd6,  8'h00, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd7,  8'h08, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd8,  8'h00, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd9,  8'hC0, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_TICK,  6'd0,  8'h00, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_TICK,  6'd63, 8'hFF, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd5,  8'hFF, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_READ,  6'd5,  8'h00, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_WRITE, 6'd10, 8'h77, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0},
        '{gsq_pkg::KIND_READ,  6'd10, 8'h00, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0}
    };

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    gsq_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    gsq_pkg::result_t result;

    // Results owed by the block, oldest first.
    gsq_pkg::result_t sound_results_due [$];

    int  failures      = 0;
    int  results_seen  = 0;
    int  sweep_cuts    = 0;
    int  len_expiries  = 0;
    int  kind_count [4] = '{0, 0, 0, 0};
    bit  calm          = 1'b0;

    // Predicted sound state.
    logic [7:0]  shadow_bytes [SHADOW_BYTES];
    logic [1:0]  duty_sel [2];
    logic [6:0]  len_left [2];
    logic [3:0]  volume [2];
    logic        env_falling [2];
    logic [10:0] period [2];
    logic        trig_armed [2];
    logic        len_gate [2];
    logic        chan_on [2];
    logic        level [2];
    logic [2:0]  wave_pos [2];
    int          period_cnt [2];
    int          len_cnt [2];
    int          env_cnt [2];
    logic [2:0]  sweep_pace;
    logic        sweep_falling;
    logic [2:0]  sweep_shift_amt;
    int          sweep_cnt;
    logic [3:0]  sweep_rounds;
    logic        sweep_live;
    logic [10:0] sweep_base;

    two_channel_square_wave_sound_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Sound state as it stands after reset.
    function automatic void sound_model_clear();
        for (int i = 0; i < SHADOW_BYTES; i++)
            shadow_bytes[i] = 8'h00;
        for (int c = 0; c < 2; c++)
        begin
            duty_sel[c]    = 2'd2;
            len_left[c]    = '0;
            volume[c]      = '0;
            env_falling[c] = 1'b0;
            period[c]      = '0;
            trig_armed[c]  = 1'b0;
            len_gate[c]    = 1'b0;
            chan_on[c]     = 1'b0;
            level[c]       = 1'b0;
            wave_pos[c]    = '0;
            period_cnt[c]  = 0;
            len_cnt[c]     = 0;
            env_cnt[c]     = 0;
        end
        sweep_pace      = '0;
        sweep_falling   = 1'b0;
        sweep_shift_amt = '0;
        sweep_cnt       = 0;
        sweep_rounds    = '0;
        sweep_live      = 1'b0;
        sweep_base      = '0;
    endfunction

    // A register write aimed at one channel's field.
    function automatic void write_field(int c, logic [2:0] field, logic [7:0] v);
        case (field)
            gsq_pkg::FIELD_SWEEP:
            begin
                if (c == 0)
                begin
                    sweep_pace      = v[6:4];
                    sweep_falling   = v[3];
                    sweep_shift_amt = v[2:0];
                end
            end
            gsq_pkg::FIELD_DUTY_LEN:
            begin
                duty_sel[c] = v[7:6];
                len_left[c] = {1'b0, v[5:0]};
            end
            gsq_pkg::FIELD_VOL_ENV:
            begin
                volume[c]      = v[7:4];
                env_falling[c] = v[3];
            end
            gsq_pkg::FIELD_PERIOD_LO:
                period[c][7:0] = v;
            gsq_pkg::FIELD_PERIOD_HI:
            begin
                period[c][10:8] = v[2:0];
                trig_armed[c]   = v[7];
                len_gate[c]     = v[6];
            end
            default:
                ;
        endcase
    endfunction

    // Trigger handling and duty stepping of one channel.
    function automatic void wave_tick(int c);
        if (trig_armed[c])
        begin
            chan_on[c] = 1'b1;
            if (len_left[c] == 0)
                len_left[c] = LENGTH_RELOAD;
            trig_armed[c] = 1'b0;
        end
        period_cnt[c]--;
        if (period_cnt[c] <= 0)
        begin
            level[c] = WAVE_BITS[{duty_sel[c], wave_pos[c]}];
            wave_pos[c]++;
            period_cnt[c] += (PERIOD_SPAN - int'(period[c])) * 4;
        end
    endfunction

    // Next sweep period in 16 bits; a result past 2047 or below zero lands above PERIOD_MAX.
    function automatic logic [15:0] sweep_target();
        logic [15:0] delta;
        delta = {5'b0, sweep_base} >> sweep_shift_amt;
        if (sweep_falling)
            return {5'b0, period[0]} - delta;
        return {5'b0, period[0]} + delta;
    endfunction

    function automatic void sweep_overflow();
        if (chan_on[0])
            sweep_cuts++;
        chan_on[0] = 1'b0;
    endfunction

    // One sweep calculation: apply in range, then check the following step once more.
    function automatic void sweep_apply();
        logic [15:0] target;
        target = sweep_target();
        if (target > PERIOD_MAX)
            sweep_overflow();
        else if (sweep_shift_amt != 0)
        begin
            period[0]  = target[10:0];
            sweep_base = target[10:0];
            target     = sweep_target();
            if (target > PERIOD_MAX)
                sweep_overflow();
        end
    endfunction

    function automatic void sweep_tick();
        sweep_cnt--;
        if (sweep_cnt > 0)
            return;
        sweep_cnt += SWEEP_TICKS;
        if (sweep_live && sweep_pace != 0)
            sweep_apply();
        if (sweep_rounds <= 1)
        begin
            sweep_base   = period[0];
            sweep_rounds = {1'b0, sweep_pace};
            sweep_live   = (sweep_pace != 0) || (sweep_shift_amt != 0);
            if (sweep_shift_amt != 0)
                sweep_apply();
        end
        else
            sweep_rounds--;
    endfunction

    // Length countdown; its timer only runs while the count is nonzero.
    function automatic void length_tick(int c);
        if (len_left[c] == 0)
            return;
        len_cnt[c]--;
        if (len_cnt[c] > 0)
            return;
        len_cnt[c] += LENGTH_TICKS;
        if (!len_gate[c])
            return;
        len_left[c]--;
        if (len_left[c] == 0)
        begin
            chan_on[c] = 1'b0;
            level[c]   = 1'b0;
            len_expiries++;
        end
    endfunction

    // Volume ramp clamped to 0..15.
    function automatic void envelope_tick(int c);
        env_cnt[c]--;
        if (env_cnt[c] > 0)
            return;
        env_cnt[c] += ENV_TICKS;
        if (env_falling[c])
        begin
            if (volume[c] > 0)
                volume[c]--;
        end
        else if (volume[c] < VOLUME_TOP)
            volume[c]++;
    endfunction

    // Advances the predicted state by one item and gives the result it produces.
    function automatic gsq_pkg::result_t sound_unit_response(gsq_pkg::item_t it);
        gsq_pkg::result_t r;
        logic [5:0] mix;
        r   = '0;
        mix = '0;
        case (it.kind)
            gsq_pkg::KIND_TICK:
            begin
                wave_tick(0);
                sweep_tick();
                length_tick(0);
                wave_tick(1);
                length_tick(1);
                envelope_tick(0);
                envelope_tick(1);
                for (int c = 0; c < 2; c++)
                    if (chan_on[c] && level[c])
                        mix += {2'b00, volume[c]} + 6'd1;
                r.sample = mix;
            end
            gsq_pkg::KIND_WRITE:
            begin
                if (it.reg_offset <= gsq_pkg::CH_ONE_LAST_OFFSET)
                    write_field(0, it.reg_offset[2:0], it.write_data);
                else if (it.reg_offset >= gsq_pkg::CH_TWO_FIRST_OFFSET &&
                         it.reg_offset <= gsq_pkg::CH_TWO_LAST_OFFSET)
                    write_field(1, 3'(it.reg_offset - gsq_pkg::CH_TWO_FIELD_BASE),
                                it.write_data);
                if (it.reg_offset < SHADOW_BYTES)
                    shadow_bytes[it.reg_offset] = it.write_data;
            end
            gsq_pkg::KIND_READ:
            begin
                if (it.reg_offset < SHADOW_BYTES)
                    r.read_data = shadow_bytes[it.reg_offset];
            end
            default:
                ;
        endcase
        r.chan_one_on = chan_on[0];
        r.chan_two_on = chan_on[1];
        return r;
    endfunction

    // Offers one item, with an occasional idle burst first, and records its result.
    task automatic offer(input gsq_pkg::item_t it, input bit pinned = 1'b0,
                         input gsq_pkg::result_t pinned_result = '0);
        gsq_pkg::result_t due;
        if (!calm && $urandom_range(0, 23) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        due = sound_unit_response(it);
        sound_results_due.push_back(pinned ? pinned_result : due);
        kind_count[it.kind]++;
    endtask

    // Programs every field of one channel with random content, usually with a trigger.
    task automatic program_channel(input int c);
        logic [5:0] base;
        logic [7:0] data;
        base = (c == 0) ? 6'd0 : gsq_pkg::CH_TWO_FIELD_BASE;
        if (c == 0)
        begin
            data = 8'($urandom_range(0, 255));
            offer({gsq_pkg::KIND_WRITE, base, data});
        end
        data[7:6] = 2'($urandom_range(0, 3));
        data[5:0] = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3))
                                               : 6'($urandom_range(0, 63));
        offer({gsq_pkg::KIND_WRITE, 6'(base + gsq_pkg::FIELD_DUTY_LEN), data});
        data = 8'($urandom_range(0, 255));
        offer({gsq_pkg::KIND_WRITE, 6'(base + gsq_pkg::FIELD_VOL_ENV), data});
        data = 8'($urandom_range(0, 255));
        offer({gsq_pkg::KIND_WRITE, 6'(base + gsq_pkg::FIELD_PERIOD_LO), data});
        data[7]   = ($urandom_range(0, 9) < 8);
        data[6]   = 1'($urandom_range(0, 1));
        data[5:3] = 3'($urandom_range(0, 7));
        data[2:0] = $urandom_range(0, 1) ? 3'd7 : 3'($urandom_range(0, 7));
        offer({gsq_pkg::KIND_WRITE, 6'(base + gsq_pkg::FIELD_PERIOD_HI), data});
    endtask

    function automatic void compare_field(string what, int want, int got);
        if (want == got)
            return;
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        else if (failures == REPORT_LIMIT + 1)
            $display("%0t: further mismatches are counted but not shown", $time);
    endfunction

    // Checks every accepted result transfer against the oldest one owed.
    always @(posedge clk)
    begin
        gsq_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (sound_results_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: result transfer with nothing owed, expected none, got %p",
                             $time, result);
            end
            else
            begin
                want = sound_results_due.pop_front();
                compare_field("sample", want.sample, result.sample);
                compare_field("read_data", want.read_data, result.read_data);
                compare_field("chan_one_on", want.chan_one_on, result.chan_one_on);
                compare_field("chan_two_on", want.chan_two_on, result.chan_two_on);
            end
        end
    end

    // Receiver: random stall bursts, and once one long hold-off to back the block up.
    initial
    begin
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 27) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Stimulus: directed table, random traffic, then drain and report.
    initial
    begin
        int pick;
        int run_len;
        int ticks_left;
        int waited;
        logic [5:0] off;
        logic [7:0] data;
        ticks_left = TICK_BUDGET;
        sound_model_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++)
            offer({PROBES[row].kind, PROBES[row].offset, PROBES[row].data}, PROBES[row].pinned,
                  {PROBES[row].sample, PROBES[row].read_data, PROBES[row].one_on,
                   PROBES[row].two_on});

        for (int op = 0; op < RANDOM_OPS; op++)
        begin
            if (op == RANDOM_OPS - CALM_OPS)
                calm = 1'b1;
            // Halfway through, pause until every owed result has come back.
            if (op == RANDOM_OPS / 2)
            begin
                item_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sound_results_due.size() != 0);
            end
            pick = $urandom_range(0, 99);
            off  = 6'($urandom_range(0, 63));
            data = 8'($urandom_range(0, 255));
            if (pick < 33)
                offer({gsq_pkg::KIND_TICK, off, data});
            else if (pick < 53)
                program_channel($urandom_range(0, 1));
            else if (pick < 64)
                offer({gsq_pkg::KIND_WRITE, off, data});
            else if (pick < 76)
                offer({gsq_pkg::KIND_READ, off, data});
            else if (pick < 81)
                offer({KIND_NOP, off, data});
            else if (pick < 86 && !calm && ticks_left > 0)
            begin
                // A run of ticks lets the duty steps of slow periods come around.
                run_len = $urandom_range(20, 60);
                ticks_left -= run_len;
                repeat (run_len)
                    offer({gsq_pkg::KIND_TICK, 6'($urandom_range(0, 63)),
                           8'($urandom_range(0, 255))});
            end
            else
                offer({gsq_pkg::KIND_WRITE,
                       6'($urandom_range(0, gsq_pkg::CH_TWO_LAST_OFFSET)), data});
        end

        item_valid <= 1'b0;
        waited = 0;
        while (sound_results_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sound_results_due.size() != 0)
        begin
            failures++;
            $display("%0t: %0d results never arrived", $time, sound_results_due.size());
        end

        $display("Covered %0d result transfers: %0d ticks, %0d writes, %0d reads, %0d no-ops,",
                 results_seen, kind_count[gsq_pkg::KIND_TICK], kind_count[gsq_pkg::KIND_WRITE],
                 kind_count[gsq_pkg::KIND_READ], kind_count[KIND_NOP]);
        $display("with %0d sweep cutoffs, %0d length expiries and stalls on both sides.",
                 sweep_cuts, len_expiries);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(RUN_LIMIT);
        $display("%0t: run did not finish in time", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
